>>> src/mahd_pkg.sv
// ----------------------------------------------------------------------------
// mahd_pkg: shared types and constants
// Field widths, configuration register codes and reset values used by the
// moving-average hysteresis detector and its channel interfaces.
// ----------------------------------------------------------------------------
package mahd_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int AVG_W       = 12;
    localparam int THRESH_W    = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 1;

    localparam logic [THRESH_W-1:0] ON_THRESHOLD_RST  = 12'd2048;
    localparam logic [THRESH_W-1:0] OFF_THRESHOLD_RST = 12'd1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ON_THRESHOLD  = 1'b0,
        REG_OFF_THRESHOLD = 1'b1
    } cfg_reg_t;

endpackage

>>> src/mahd_sample_if.sv
// ----------------------------------------------------------------------------
// mahd_sample_if: sample channel
// Valid/ready channel carrying one raw converter sample per transfer.
// ----------------------------------------------------------------------------
interface mahd_sample_if
    import mahd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

>>> src/mahd_result_if.sv
// ----------------------------------------------------------------------------
// mahd_result_if: result channel
// Valid/ready channel carrying the detector flag and the window average.
// ----------------------------------------------------------------------------
interface mahd_result_if
    import mahd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             detected;
    logic [AVG_W-1:0] average;

    modport source (output valid, output detected, output average, input ready);
    modport sink   (input valid, input detected, input average, output ready);
endinterface

>>> src/moving_average_hysteresis_detector_unit.sv
// ----------------------------------------------------------------------------
// moving_average_hysteresis_detector_unit: windowed average with hysteresis
// Averages the last DEPTH samples and drives an on/off flag from the average.
// ----------------------------------------------------------------------------
// Usage:
//   samples : one 12-bit converter reading per transfer; the low SAMPLE_BITS
//             bits enter a DEPTH-long window.
//   results : one transfer per sample, carrying the flag after that sample
//             and the truncated window average.
//   cfg_*   : write on/off thresholds (index 0 and 1) while the unit is idle.
// From the sample transfer to results.valid, the sum updates at the transfer
//   edge, then the reciprocal multiply is registered, then compare and output.
// Throughput is one sample per cycle while the receiver takes results, set by
//   the sum update and the hysteresis update at the output stage.
// Reset clears the window, the sum and the flag and loads the threshold
//   defaults; the unit takes samples as soon as reset is released.
// When the receiver stalls, the output register holds its result and the
//   stages behind it keep filling; samples.ready drops only once all three
//   stages hold an item.
// ----------------------------------------------------------------------------
module moving_average_hysteresis_detector_unit
    import mahd_pkg::*;
#(
    parameter int DEPTH       = 8,
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    mahd_sample_if.sink            samples,
    mahd_result_if.source          results,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(DEPTH);
    localparam int CMP_W = SAMPLE_BITS + THRESH_W;

    // ------------------------------------------------------------------
    // Threshold registers
    // ------------------------------------------------------------------
    logic [THRESH_W-1:0] on_thresh_reg;
    logic [THRESH_W-1:0] on_thresh_next;
    logic [THRESH_W-1:0] off_thresh_reg;
    logic [THRESH_W-1:0] off_thresh_next;

    always_comb
    begin
        on_thresh_next  = on_thresh_reg;
        off_thresh_next = off_thresh_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ON_THRESHOLD:  on_thresh_next  = cfg_data[THRESH_W-1:0];
                REG_OFF_THRESHOLD: off_thresh_next = cfg_data[THRESH_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_thresh_reg  <= ON_THRESHOLD_RST;
            off_thresh_reg <= OFF_THRESHOLD_RST;
        end
        else
        begin
            on_thresh_reg  <= on_thresh_next;
            off_thresh_reg <= off_thresh_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage control: each stage advances when the one ahead frees up
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s2_adv;
    logic s2_free;
    logic s1_adv;
    logic s1_free;
    logic accept;

    assign out_free = !out_valid_reg || results.ready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;

    assign samples.ready = s1_free;
    assign accept        = samples.valid && s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: sample window and running sum
    // The window is a shift line; the oldest sample falls off the far end
    // and is subtracted as the new one is added. The sum register doubles
    // as the stage 1 payload: it only changes when stage 1 takes a sample.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0]          ring_reg [DEPTH];
    logic [SUM_W-1:0]                sum_reg;
    logic [SUM_W-1:0]                sum_next;
    logic [SAMPLE_BITS+SAMPLE_W-1:0] sample_wide;
    logic [SAMPLE_BITS-1:0]          sample_val;

    // keep only the low SAMPLE_BITS bits, zero-extend when wider than the port
    assign sample_wide = {{SAMPLE_BITS{1'b0}}, samples.sample};
    assign sample_val  = sample_wide[SAMPLE_BITS-1:0];

    assign sum_next = sum_reg + SUM_W'(sample_val) - SUM_W'(ring_reg[DEPTH-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (accept)
        begin
            ring_reg[0] <= sample_val;
            for (int i = 1; i < DEPTH; i++)
            begin
                ring_reg[i] <= ring_reg[i-1];
            end
            sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum / DEPTH by reciprocal multiply
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] quotient;

    mahd_recip_div #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_div (
        .clk      (clk),
        .load     (s1_adv),
        .sum      (sum_reg),
        .quotient (quotient)
    );

    // ------------------------------------------------------------------
    // Stage 3: hysteresis compare and output register
    // Compare the full quotient; the reported average is cut to 12 bits.
    // ------------------------------------------------------------------
    logic             flag_reg;
    logic             flag_next;
    logic [AVG_W-1:0] average_reg;
    logic [CMP_W-1:0] avg_cmp;
    logic [CMP_W-1:0] on_cmp;
    logic [CMP_W-1:0] off_cmp;

    assign avg_cmp = CMP_W'(quotient);
    assign on_cmp  = CMP_W'(on_thresh_reg);
    assign off_cmp = CMP_W'(off_thresh_reg);

    always_comb
    begin
        flag_next = flag_reg;
        if (flag_reg)
        begin
            if (avg_cmp < off_cmp)
            begin
                flag_next = 1'b0;
            end
        end
        else if (avg_cmp >= on_cmp)
        begin
            flag_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            average_reg <= avg_cmp[AVG_W-1:0];
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.detected = flag_reg;
    assign results.average  = average_reg;

endmodule

>>> src/mahd_recip_div.sv
// ----------------------------------------------------------------------------
// mahd_recip_div: divide the window sum by DEPTH
// Multiplies by a fixed reciprocal into a register and takes the high bits;
// the reciprocal is rounded up so the quotient is exact over the sum range.
// ----------------------------------------------------------------------------
module mahd_recip_div
    import mahd_pkg::*;
#(
    parameter int DEPTH       = 8,
    parameter int SAMPLE_BITS = 12,
    parameter int SUM_W       = 15
)
(
    input  logic                   clk,
    input  logic                   load,
    input  logic [SUM_W-1:0]       sum,
    output logic [SAMPLE_BITS-1:0] quotient
);

    localparam int L        = $clog2(DEPTH);
    localparam int SHIFT    = SUM_W + L;
    localparam int RECIP_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

    logic [PROD_W-1:0] product_reg;
    logic [PROD_W-1:0] product_next;

    assign product_next = PROD_W'(sum) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= product_next;
        end
    end

    // drop the fraction bits
    assign quotient = product_reg[SHIFT +: SAMPLE_BITS];

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: moving-average hysteresis detector check
// Feeds converter samples through the valid/ready sample channel, predicts
// the window average and the hysteresis flag for every transfer, and checks
// each result transfer against the oldest prediction. Thresholds are
// rewritten between phases while the unit is idle. Both channels idle and
// stall in random bursts, and the receiver holds off long enough to back the
// pipeline up into the sample channel.
// ----------------------------------------------------------------------------
module testbench
    import mahd_pkg::*;
;

    localparam int WINDOW_DEPTH = 8;
    localparam int PIPE_LATENCY = 3;
    localparam int LONG_HOLD    = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_SAMPLE   = (1 << SAMPLE_W) - 1;
    localparam int MAX_THRESH   = (1 << THRESH_W) - 1;

    typedef struct packed {
        logic             detected;
        logic [AVG_W-1:0] average;
    } detector_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    mahd_sample_if sample_bus ();
    mahd_result_if result_bus ();

    moving_average_hysteresis_detector_unit #(
        .DEPTH       (WINDOW_DEPTH),
        .SAMPLE_BITS (SAMPLE_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_bus),
        .results   (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Samples waiting for the driver, and detector results still owed by the unit.
    logic [SAMPLE_W-1:0] pending_samples [$];
    detector_result_t    expected_results [$];

    // Predicted detector state: window contents, running sum, oldest slot,
    // hysteresis flag and the thresholds last written.
    logic [SAMPLE_W-1:0] window_ring [WINDOW_DEPTH];
    int unsigned         window_sum;
    int unsigned         oldest_slot;
    bit                  flag_state;
    logic [THRESH_W-1:0] on_level;
    logic [THRESH_W-1:0] off_level;

    int  queued_count;
    int  accepted_count;
    int  result_count;
    int  error_count;
    int  cycle_count;
    int  idle_pct;
    bit  steady_tail;
    bit  sample_taken;
    int  send_gap;
    int  stall_left;
    int  hold_left;
    int  hold_mark;

    always #6 clk = ~clk;

    // Advance the predicted window by one sample and queue the expected result.
    function automatic void predict_detection(logic [SAMPLE_W-1:0] value);
        detector_result_t predicted;
        int unsigned      mean;
        window_sum = window_sum + 32'(value) - 32'(window_ring[oldest_slot]);
        window_ring[oldest_slot] = value;
        oldest_slot = (oldest_slot == WINDOW_DEPTH - 1) ? 0 : oldest_slot + 1;
        mean = window_sum / WINDOW_DEPTH;
        // Hysteresis: only the off threshold matters while on, only the on
        // threshold while off. Crossed thresholds may toggle every sample.
        if (flag_state)
        begin
            if (mean < 32'(off_level))
                flag_state = 1'b0;
        end
        else if (mean >= 32'(on_level))
        begin
            flag_state = 1'b1;
        end
        predicted.detected = flag_state;
        predicted.average  = mean[AVG_W-1:0];
        expected_results.push_back(predicted);
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp_sample(int value);
        if (value < 0)
            return '0;
        if (value > MAX_SAMPLE)
            return SAMPLE_W'(MAX_SAMPLE);
        return SAMPLE_W'(value);
    endfunction

    // Mostly samples near a target level so the average wanders across the
    // thresholds; the rest is full-range noise and rail values.
    function automatic logic [SAMPLE_W-1:0] next_sample(int level);
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return clamp_sample(level + $urandom_range(256) - 128);
        if (pick < 85)
            return SAMPLE_W'($urandom_range(MAX_SAMPLE));
        return $urandom_range(1) ? SAMPLE_W'(MAX_SAMPLE) : '0;
    endfunction

    task automatic queue_sample(logic [SAMPLE_W-1:0] value);
        pending_samples.push_back(value);
        queued_count++;
    endtask

    // Wait until every queued sample went in and every result came out, then
    // let the pipeline settle.
    task automatic wait_idle();
        while (accepted_count != queued_count || expected_results.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 3) @(negedge clk);
    endtask

    task automatic write_threshold(cfg_reg_t which, logic [THRESH_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (which == REG_ON_THRESHOLD)
            on_level = value;
        else
            off_level = value;
    endtask

    task automatic set_thresholds(logic [THRESH_W-1:0] on_value,
                                  logic [THRESH_W-1:0] off_value);
        wait_idle();
        write_threshold(REG_ON_THRESHOLD, on_value);
        write_threshold(REG_OFF_THRESHOLD, off_value);
    endtask

    // Sender: load the next sample once the current one has transferred,
    // with random gaps after some transfers.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_bus.valid <= 1'b0;
        end
        else if (sample_taken || !sample_bus.valid)
        begin
            sample_taken = 1'b0;
            if (send_gap > 0 && !steady_tail)
            begin
                send_gap--;
                sample_bus.valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                sample_bus.sample <= pending_samples.pop_front();
                sample_bus.valid  <= 1'b1;
                if (!steady_tail && $urandom_range(99) < idle_pct)
                    send_gap = $urandom_range(1, 12);
                else
                    send_gap = 0;
            end
            else
            begin
                sample_bus.valid <= 1'b0;
            end
        end
    end

    // Predict on each sample transfer.
    always @(posedge clk)
    begin
        if (rst_n && sample_bus.valid && sample_bus.ready)
        begin
            predict_detection(sample_bus.sample);
            accepted_count++;
            sample_taken = 1'b1;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off at a few marks so the
    // pipeline fills and the unit drops samples.ready.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end
        else if (rst_n && !steady_tail && result_count >= hold_mark)
        begin
            hold_left = LONG_HOLD - 1;
            hold_mark += 500;
            result_bus.ready <= 1'b0;
        end
        else if (stall_left > 0 && !steady_tail)
        begin
            stall_left--;
            result_bus.ready <= 1'b0;
        end
        else
        begin
            result_bus.ready <= 1'b1;
            if (!steady_tail && $urandom_range(99) < idle_pct)
                stall_left = $urandom_range(1, 12);
            else
                stall_left = 0;
        end
    end

    // Check each result transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no prediction waiting: detected %0d average %0d",
                       result_bus.detected, result_bus.average);
                error_count++;
            end
            else
            begin
                detector_result_t predicted;
                predicted = expected_results.pop_front();
                if (result_bus.detected !== predicted.detected)
                begin
                    $error("detected mismatch: expected %0d, actual %0d",
                           predicted.detected, result_bus.detected);
                    error_count++;
                end
                if (result_bus.average !== predicted.average)
                begin
                    $error("average mismatch: expected %0d, actual %0d",
                           predicted.average, result_bus.average);
                    error_count++;
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int level;
        int run_left;
        logic [THRESH_W-1:0] on_pick;
        logic [THRESH_W-1:0] off_pick;

        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_ON_THRESHOLD;
        cfg_data          = '0;
        sample_bus.valid  = 1'b0;
        sample_bus.sample = '0;
        result_bus.ready  = 1'b0;
        queued_count      = 0;
        accepted_count    = 0;
        result_count      = 0;
        error_count       = 0;
        cycle_count       = 0;
        idle_pct          = 20;
        steady_tail       = 1'b0;
        sample_taken      = 1'b0;
        send_gap          = 0;
        stall_left        = 0;
        hold_left         = 0;
        hold_mark         = 150;
        for (int i = 0; i < WINDOW_DEPTH; i++)
            window_ring[i] = '0;
        window_sum  = 0;
        oldest_slot = 0;
        flag_state  = 1'b0;
        on_level    = ON_THRESHOLD_RST;
        off_level   = OFF_THRESHOLD_RST;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset thresholds. The first samples land in a window still holding
        // zeros; then a run of rail samples turns the flag on and a zero window
        // walks the average down through the off threshold.
        queue_sample(SAMPLE_W'(MAX_SAMPLE));
        queue_sample(12'hAAA);
        queue_sample(12'h555);
        repeat (7) queue_sample(SAMPLE_W'(MAX_SAMPLE));
        repeat (8) queue_sample('0);
        queue_sample(12'd2048);
        queue_sample(SAMPLE_W'(MAX_SAMPLE - 1));

        // Crossed thresholds: the flag toggles on every sample.
        set_thresholds('0, THRESH_W'(MAX_THRESH));
        repeat (4) queue_sample(SAMPLE_W'($urandom_range(MAX_SAMPLE)));

        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: begin on_pick = THRESH_W'(MAX_THRESH); off_pick = THRESH_W'(MAX_THRESH); end
                1: begin on_pick = '0;                    off_pick = '0;                    end
                2: begin on_pick = THRESH_W'(MAX_THRESH); off_pick = '0;                    end
                3: begin on_pick = 12'd100;               off_pick = 12'd3000;              end
                default:
                begin
                    on_pick = THRESH_W'($urandom_range(MAX_THRESH));
                    if ($urandom_range(99) < 80)
                        off_pick = THRESH_W'($urandom_range(32'(on_pick)));
                    else
                        off_pick = THRESH_W'($urandom_range(MAX_THRESH));
                end
            endcase
            set_thresholds(on_pick, off_pick);

            idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 15 : 40;
            steady_tail = (phase == 9);

            run_left = 0;
            level    = 0;
            for (int n = 0; n < 103; n++)
            begin
                if (run_left == 0)
                begin
                    case ($urandom_range(3))
                        0: level = int'(on_level);
                        1: level = int'(off_level);
                        2: level = $urandom_range(MAX_SAMPLE);
                        default: level = $urandom_range(1) ? MAX_SAMPLE : 0;
                    endcase
                    level    = level + $urandom_range(512) - 256;
                    run_left = $urandom_range(8, 24);
                end
                run_left--;
                queue_sample(next_sample(level));
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
